### src/hcts_pkg.sv
// shared types and constants for the hand clasp toggle and swipe detector
`timescale 1ns / 1ps

package hcts_pkg;

	// configuration register indexes
	localparam int CfgIdxW = 3;
	typedef enum logic [CfgIdxW-1:0] {
		CFG_HOLD_TIME    = 3'd0,
		CFG_SWIPE_WINDOW = 3'd1,
		CFG_RIGHT_ZONE   = 3'd2,
		CFG_LEFT_ZONE    = 3'd3,
		CFG_X_TOL        = 3'd4,
		CFG_Y_TOL        = 3'd5
	} cfg_idx_t;

	localparam int CfgDataW = 16;

	// swipe codes
	typedef enum logic [1:0] {
		SWIPE_NONE  = 2'd0,
		SWIPE_LEFT  = 2'd1,
		SWIPE_RIGHT = 2'd2
	} swipe_t;

	// register reset values
	localparam logic [15:0]        HoldTimeRst    = 16'd5000;
	localparam logic [15:0]        SwipeWindowRst = 16'd200;
	localparam logic signed [15:0] RightZoneRst   = 16'sd614;
	localparam logic signed [15:0] LeftZoneRst    = -16'sd614;
	localparam logic [14:0]        XTolRst        = 15'd819;
	localparam logic [14:0]        YTolRst        = 15'd2048;

	// live configuration
	typedef struct packed {
		logic [15:0]        hold_time_ms;
		logic [15:0]        swipe_window_ms;
		logic signed [15:0] right_zone_x;
		logic signed [15:0] left_zone_x;
		logic [14:0]        x_tolerance;
		logic [14:0]        y_tolerance;
	} cfg_t;

	// one skeleton frame
	typedef struct packed {
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic [31:0]        now_ms;
	} frame_t;

	// one result beat
	typedef struct packed {
		swipe_t swipe;
		logic   sliding_on;
		logic   sliding_changed;
	} result_t;

endpackage

### src/hcts_if.sv
// handshake channel interfaces for frames and results
`timescale 1ns / 1ps

interface hcts_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic [31:0]        now_ms;

	modport source (output valid, left_x, left_y, right_x, right_y, now_ms, input ready);
	modport sink (input valid, left_x, left_y, right_x, right_y, now_ms, output ready);
endinterface

interface hcts_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] swipe;
	logic       sliding_on;
	logic       sliding_changed;

	modport source (output valid, swipe, sliding_on, sliding_changed, input ready);
	modport sink (input valid, swipe, sliding_on, sliding_changed, output ready);
endinterface

### src/hand_clasp_toggle_swipe_detector.sv
// top level of the hand clasp toggle and swipe detector
`timescale 1ns / 1ps

// Takes skeleton frames and returns one result per frame, in
// order. A frame is captured in an input register, evaluated against the
// gesture state combinationally and written to the result register, so
// throughput is one frame per cycle while the result side keeps ready
// high; the state loop through the core allows that rate. A held result
// lets the input register take one more beat, and the input stalls once
// both registers hold a frame.
// Configuration writes are meant for idle periods.

module hand_clasp_toggle_swipe_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	hcts_frame_if.sink                    frame,
	hcts_result_if.source                 result,
	input  logic                          wr_en,
	input  logic [hcts_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [hcts_pkg::CfgDataW-1:0] wr_data
);

	hcts_pkg::cfg_t    cfg;
	hcts_pkg::frame_t  frame_s1;
	logic              valid_s1;
	hcts_pkg::result_t res_comb;
	hcts_pkg::result_t res_s2;
	logic              valid_s2;
	logic              adv;
	logic              take;

	hcts_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// pipeline handshake
	assign adv         = valid_s1 && (!valid_s2 || result.ready);
	assign frame.ready = !valid_s1 || adv;
	assign take        = frame.valid && frame.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_s1.left_x  <= frame.left_x;
			frame_s1.left_y  <= frame.left_y;
			frame_s1.right_x <= frame.right_x;
			frame_s1.right_y <= frame.right_y;
			frame_s1.now_ms  <= frame.now_ms;
		end
	end

	hcts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.frame  (frame_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid           = valid_s2;
	assign result.swipe           = res_s2.swipe;
	assign result.sliding_on      = res_s2.sliding_on;
	assign result.sliding_changed = res_s2.sliding_changed;

endmodule

### src/hcts_cfg_regs.sv
// configuration register file with write port
`timescale 1ns / 1ps

module hcts_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [hcts_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [hcts_pkg::CfgDataW-1:0] wr_data,
	output hcts_pkg::cfg_t                cfg
);

	hcts_pkg::cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time_ms    <= hcts_pkg::HoldTimeRst;
			cfg_q.swipe_window_ms <= hcts_pkg::SwipeWindowRst;
			cfg_q.right_zone_x    <= hcts_pkg::RightZoneRst;
			cfg_q.left_zone_x     <= hcts_pkg::LeftZoneRst;
			cfg_q.x_tolerance     <= hcts_pkg::XTolRst;
			cfg_q.y_tolerance     <= hcts_pkg::YTolRst;
		end else if (wr_en) begin
			case (wr_index)
				hcts_pkg::CFG_HOLD_TIME:    cfg_q.hold_time_ms    <= wr_data;
				hcts_pkg::CFG_SWIPE_WINDOW: cfg_q.swipe_window_ms <= wr_data;
				hcts_pkg::CFG_RIGHT_ZONE:   cfg_q.right_zone_x    <= $signed(wr_data);
				hcts_pkg::CFG_LEFT_ZONE:    cfg_q.left_zone_x     <= $signed(wr_data);
				hcts_pkg::CFG_X_TOL:        cfg_q.x_tolerance     <= wr_data[14:0];
				hcts_pkg::CFG_Y_TOL:        cfg_q.y_tolerance     <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/hcts_core.sv
// gesture state and combinational clasp and swipe evaluation
`timescale 1ns / 1ps

module hcts_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  hcts_pkg::frame_t    frame,
	input  hcts_pkg::cfg_t      cfg,
	output hcts_pkg::result_t   result
);

	logic        sliding_q;
	logic        in_right_q;
	logic        in_left_q;
	logic [31:0] last_left_q;
	logic [31:0] last_right_q;
	logic [31:0] clasp_start_q;

	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [16:0]        mag_x;
	logic [16:0]        mag_y;
	logic               close_x;
	logic               close_y;
	logic [31:0]        clasp_elapsed;
	logic [31:0]        left_elapsed;
	logic [31:0]        right_elapsed;
	logic               toggle;
	logic               restart;
	logic               slide_nxt;
	logic               hit_right;
	logic               hit_left;
	hcts_pkg::swipe_t   swipe;

	// hand separation magnitudes
	assign dx    = {frame.left_x[15], frame.left_x} - {frame.right_x[15], frame.right_x};
	assign dy    = {frame.left_y[15], frame.left_y} - {frame.right_y[15], frame.right_y};
	assign mag_x = dx[16] ? 17'(-dx) : 17'(dx);
	assign mag_y = dy[16] ? 17'(-dy) : 17'(dy);
	assign close_x = mag_x < {2'b00, cfg.x_tolerance};
	assign close_y = mag_y < {2'b00, cfg.y_tolerance};

	// clasp hold timer, wrapping difference
	assign clasp_elapsed = frame.now_ms - clasp_start_q;
	assign toggle    = close_x && close_y && (clasp_elapsed > {16'd0, cfg.hold_time_ms});
	assign restart   = !close_x || toggle;
	assign slide_nxt = sliding_q ^ toggle;

	// zone test uses the sliding mode after this frame's toggle
	assign hit_right = slide_nxt && (frame.right_x > cfg.right_zone_x);
	assign hit_left  = slide_nxt && !hit_right && (frame.right_x < cfg.left_zone_x);
	assign left_elapsed  = frame.now_ms - last_left_q;
	assign right_elapsed = frame.now_ms - last_right_q;

	always_comb begin
		swipe = hcts_pkg::SWIPE_NONE;
		if (hit_right && in_left_q && (left_elapsed < {16'd0, cfg.swipe_window_ms})) begin
			swipe = hcts_pkg::SWIPE_RIGHT;
		end else if (hit_left && in_right_q &&
				(right_elapsed < {16'd0, cfg.swipe_window_ms})) begin
			swipe = hcts_pkg::SWIPE_LEFT;
		end
	end

	// state update when the frame moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sliding_q     <= 1'b0;
			in_right_q    <= 1'b0;
			in_left_q     <= 1'b0;
			last_left_q   <= '0;
			last_right_q  <= '0;
			clasp_start_q <= '0;
		end else if (adv) begin
			sliding_q <= slide_nxt;
			if (restart) begin
				clasp_start_q <= frame.now_ms;
			end
			if (hit_right) begin
				in_right_q   <= 1'b1;
				in_left_q    <= 1'b0;
				last_right_q <= frame.now_ms;
			end else if (hit_left) begin
				in_right_q  <= 1'b0;
				in_left_q   <= 1'b1;
				last_left_q <= frame.now_ms;
			end
		end
	end

	assign result.swipe           = swipe;
	assign result.sliding_on      = slide_nxt;
	assign result.sliding_changed = toggle;

endmodule

### src/hcts_checker.sv
// port-level assertions for the detector, bound to the top level
`timescale 1ns / 1ps

module hcts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] swipe,
	input logic       sliding_on,
	input logic       sliding_changed
);

	logic       in_beat;
	logic       out_beat;
	logic       mode_q;
	logic [1:0] pending_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// last delivered sliding mode and frames in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			pending_q <= '0;
		end else begin
			if (out_beat) begin
				mode_q <= sliding_on;
			end
			pending_q <= pending_q + 2'(in_beat) - 2'(out_beat);
		end
	end

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(swipe) &&
		$stable(sliding_on) && $stable(sliding_changed))
		else $error("result changed while stalled");

	// mode only flips on a toggle beat
	a_mode_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> sliding_on == (mode_q ^ sliding_changed))
		else $error("sliding mode inconsistent with toggle flag");

	// swipes only while sliding, and never the unused code
	a_swipe_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && swipe != hcts_pkg::SWIPE_NONE |-> sliding_on &&
		(swipe == hcts_pkg::SWIPE_LEFT || swipe == hcts_pkg::SWIPE_RIGHT))
		else $error("swipe reported while sliding off");

	// no more than two frames in flight
	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many frames in flight");

	// results never outnumber frames
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> !out_valid)
		else $error("result without a frame");

endmodule

bind hand_clasp_toggle_swipe_detector hcts_checker u_hcts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (frame.valid),
	.in_ready        (frame.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.swipe           (result.swipe),
	.sliding_on      (result.sliding_on),
	.sliding_changed (result.sliding_changed)
);

### bench/hand_clasp_toggle_swipe_detector_tb.sv
// self-checking testbench for the hand clasp toggle and swipe detector
`timescale 1ns / 1ps

module hand_clasp_toggle_swipe_detector_tb;

	localparam int IdlePct       = 37;
	localparam int HoldOffCycles = 120;
	localparam int DrainCycles   = 4;
	localparam int QuietLimit    = 2000;

	// indexes with no register behind them
	localparam logic [hcts_pkg::CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
	localparam logic [hcts_pkg::CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          wr_en;
	logic [hcts_pkg::CfgIdxW-1:0]  wr_index;
	logic [hcts_pkg::CfgDataW-1:0] wr_data;

	hcts_frame_if  frame_ch ();
	hcts_result_if result_ch ();

	hand_clasp_toggle_swipe_detector i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// gesture state of the predictor
	hcts_pkg::cfg_t live_cfg;
	logic           slide_on;
	logic           at_right;
	logic           at_left;
	logic [31:0]    left_seen_ms;
	logic [31:0]    right_seen_ms;
	logic [31:0]    clasp_ms;

	hcts_pkg::result_t pending_verdicts[$];
	int                bad_verdicts  = 0;
	int                idle_pct      = IdlePct;
	int                hold_off_req  = 0;
	logic [31:0]       clock_ms      = 32'd0;

	// clasp toggle first, then the zone test on the right hand
	function automatic hcts_pkg::result_t judge_frame(input hcts_pkg::frame_t f);
		int                dx;
		int                dy;
		logic [31:0]       since;
		hcts_pkg::result_t r;
		dx = int'($signed(f.left_x)) - int'($signed(f.right_x));
		dy = int'($signed(f.left_y)) - int'($signed(f.right_y));
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		r.swipe = hcts_pkg::SWIPE_NONE;
		r.sliding_changed = 1'b0;
		if (dx < int'(live_cfg.x_tolerance)) begin
			// close in x but apart in y leaves the timer alone
			if (dy < int'(live_cfg.y_tolerance)) begin
				since = f.now_ms - clasp_ms;
				if (since > 32'(live_cfg.hold_time_ms)) begin
					slide_on = ~slide_on;
					r.sliding_changed = 1'b1;
					clasp_ms = f.now_ms;
				end
			end
		end else begin
			clasp_ms = f.now_ms;
		end
		if (slide_on) begin
			if ($signed(f.right_x) > live_cfg.right_zone_x) begin
				since = f.now_ms - left_seen_ms;
				if (at_left && since < 32'(live_cfg.swipe_window_ms))
					r.swipe = hcts_pkg::SWIPE_RIGHT;
				at_right = 1'b1;
				at_left = 1'b0;
				right_seen_ms = f.now_ms;
			end else if ($signed(f.right_x) < live_cfg.left_zone_x) begin
				since = f.now_ms - right_seen_ms;
				if (at_right && since < 32'(live_cfg.swipe_window_ms))
					r.swipe = hcts_pkg::SWIPE_LEFT;
				at_right = 1'b0;
				at_left = 1'b1;
				left_seen_ms = f.now_ms;
			end
		end
		r.sliding_on = slide_on;
		return r;
	endfunction

	function automatic int clamp16(input int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	// one frame beat, with random idle cycles ahead of it
	task automatic send_frame(input int lx, input int ly, input int rx, input int ry,
			input logic [31:0] t);
		hcts_pkg::frame_t f;
		f.left_x = 16'(lx);
		f.left_y = 16'(ly);
		f.right_x = 16'(rx);
		f.right_y = 16'(ry);
		f.now_ms = t;
		while ($urandom_range(99) < idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.left_x <= f.left_x;
		frame_ch.left_y <= f.left_y;
		frame_ch.right_x <= f.right_x;
		frame_ch.right_y <= f.right_y;
		frame_ch.now_ms <= f.now_ms;
		@(posedge clk);
		while (!frame_ch.ready) @(posedge clk);
		pending_verdicts.push_back(judge_frame(f));
	endtask

	// stop offering frames and let every owed result come back
	task automatic wait_idle();
		frame_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [hcts_pkg::CfgIdxW-1:0] idx,
			input logic [hcts_pkg::CfgDataW-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			hcts_pkg::CFG_HOLD_TIME:    live_cfg.hold_time_ms = data;
			hcts_pkg::CFG_SWIPE_WINDOW: live_cfg.swipe_window_ms = data;
			hcts_pkg::CFG_RIGHT_ZONE:   live_cfg.right_zone_x = data;
			hcts_pkg::CFG_LEFT_ZONE:    live_cfg.left_zone_x = data;
			hcts_pkg::CFG_X_TOL:        live_cfg.x_tolerance = data[14:0];
			hcts_pkg::CFG_Y_TOL:        live_cfg.y_tolerance = data[14:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] hold, input logic [15:0] window,
			input logic [15:0] rz, input logic [15:0] lz, input logic [15:0] xt,
			input logic [15:0] yt);
		wait_idle();
		write_reg(hcts_pkg::CFG_HOLD_TIME, hold);
		write_reg(hcts_pkg::CFG_SWIPE_WINDOW, window);
		write_reg(hcts_pkg::CFG_RIGHT_ZONE, rz);
		write_reg(hcts_pkg::CFG_LEFT_ZONE, lz);
		write_reg(hcts_pkg::CFG_X_TOL, xt);
		write_reg(hcts_pkg::CFG_Y_TOL, yt);
	endtask

	// clasps near the hold limit, sweeps across the zones, and some noise
	task automatic send_gesture_items(input int count);
		int          rz;
		int          lz;
		int          xt;
		int          yt;
		int          lx;
		int          ly;
		int          rx;
		int          ry;
		int          off;
		int          sep;
		logic [31:0] t;
		repeat (count) begin
			rz = int'(live_cfg.right_zone_x);
			lz = int'(live_cfg.left_zone_x);
			xt = int'(live_cfg.x_tolerance);
			yt = int'(live_cfg.y_tolerance);
			off = int'($urandom_range(99));
			if (off < 15) begin
				// hands together, timed right around the hold limit
				lx = int'($urandom_range(65535)) - 32768;
				ly = int'($urandom_range(65535)) - 32768;
				off = (xt == 0) ? 0 : int'($urandom_range(xt - 1));
				if ($urandom_range(9) == 0) off = xt;
				rx = (lx >= 0) ? lx - off : lx + off;
				off = (yt == 0) ? 0 : int'($urandom_range(yt - 1));
				if ($urandom_range(9) == 0) off = yt;
				ry = (ly >= 0) ? ly - off : ly + off;
				t = clasp_ms + 32'(live_cfg.hold_time_ms) +
					(($urandom_range(3) == 0) ? $urandom_range(3000) : $urandom_range(2));
			end else if (off < 80) begin
				// hands apart, right hand moving between zones
				case ($urandom_range(7))
					0, 1, 2: rx = clamp16(rz + 1 + int'($urandom_range(4000)));
					3, 4, 5: rx = clamp16(lz - 1 - int'($urandom_range(4000)));
					6:       rx = ($urandom_range(1) == 0) ? rz : lz;
					default: rx = (rz > lz) ? lz + int'($urandom_range(rz - lz)) : rz;
				endcase
				sep = xt + int'($urandom_range(2000));
				if (sep > 32768) sep = 32768;
				lx = (rx >= 0) ? rx - sep : rx + sep;
				ly = int'($urandom_range(65535)) - 32768;
				ry = int'($urandom_range(65535)) - 32768;
				if ($urandom_range(4) == 0) begin
					// land on the edge of the swipe window
					t = ((rx > rz) ? left_seen_ms : right_seen_ms) +
						32'(live_cfg.swipe_window_ms) - 32'd1 + $urandom_range(1);
				end else begin
					t = clock_ms + $urandom_range(int'(live_cfg.swipe_window_ms) * 3 / 2 + 2);
				end
			end else begin
				lx = int'($urandom_range(65535)) - 32768;
				ly = int'($urandom_range(65535)) - 32768;
				rx = int'($urandom_range(65535)) - 32768;
				ry = int'($urandom_range(65535)) - 32768;
				t = ($urandom_range(3) == 0) ? $urandom : clock_ms + $urandom_range(500);
			end
			clock_ms = t;
			send_frame(lx, ly, rx, ry, t);
		end
	endtask

	// clasp and swipe walk at reset settings
	task automatic test_clasp_and_swipe();
		send_frame(-32768, -32768, 32767, 32767, 32'd0);
		send_frame(32767, 32767, -32768, -32768, 32'd100);
		// close in x, apart in y
		send_frame(0, 0, 0, 4000, 32'd6000);
		// hold elapsed exactly equal to the limit
		send_frame(500, 0, 500, 0, 32'd5100);
		// toggle on, new state already sees the right zone
		send_frame(500, 0, 700, 0, 32'd5101);
		send_frame(-2000, 0, -700, 0, 32'd5201);
		// between zones and on the zone limits
		send_frame(-4000, 0, 0, 0, 32'd5250);
		send_frame(-4000, 0, 614, 0, 32'd5300);
		send_frame(-4000, 0, 615, 0, 32'd5400);
		send_frame(-4000, 0, -614, 0, 32'd5500);
		// crossing takes exactly the window
		send_frame(-4000, 0, -615, 0, 32'd5600);
		// re-entering the same zone
		send_frame(-4000, 0, -32768, 0, 32'd5650);
		send_frame(-4000, 0, 32767, 0, 32'd5700);
		// toggle off, zone moves ignored while off
		send_frame(-1000, 0, -1000, 0, 32'd10701);
		send_frame(4000, 0, -2000, 0, 32'd10750);
		// separations exactly at the tolerances
		send_frame(819, 0, 0, 0, 32'd10800);
		send_frame(0, 2048, 0, 0, 32'd20000);
		send_frame(0, 2047, 0, 0, 32'd20000);
	endtask

	// elapsed times across the 32-bit wrap
	task automatic test_timestamp_wrap();
		send_frame(-4000, 0, 1000, 0, 32'hFFFF_FFFF);
		send_frame(-4000, 0, -1000, 0, 32'h0000_0040);
		send_frame(100, 100, 100, 100, 32'h0000_1400);
	endtask

	// every register at both ends of its range, plus unmapped indexes
	task automatic test_register_extremes();
		set_config(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF);
		write_reg(CfgIdxSpareLo, 16'h1234);
		write_reg(CfgIdxSpareHi, 16'hFFFF);
		send_gesture_items(60);
		set_config(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
		send_gesture_items(60);
	endtask

	// full rate on both sides, then a long result stall
	task automatic test_backpressure();
		set_config(16'd20, hcts_pkg::SwipeWindowRst, hcts_pkg::RightZoneRst,
			hcts_pkg::LeftZoneRst, 16'(hcts_pkg::XTolRst), 16'(hcts_pkg::YTolRst));
		idle_pct = 0;
		send_gesture_items(150);
		hold_off_req++;
		send_gesture_items(60);
		idle_pct = IdlePct;
	endtask

	// random settings, gesture sequences in each
	task automatic test_random_gestures();
		logic [15:0] hold;
		logic [15:0] window;
		logic [15:0] rz;
		logic [15:0] lz;
		logic [15:0] xt;
		logic [15:0] yt;
		repeat (5) begin
			case ($urandom_range(3))
				0, 1:    hold = 16'($urandom_range(60));
				2:       hold = hcts_pkg::HoldTimeRst;
				default: hold = 16'($urandom);
			endcase
			case ($urandom_range(3))
				0, 1:    window = 16'($urandom_range(400));
				2:       window = hcts_pkg::SwipeWindowRst;
				default: window = 16'($urandom);
			endcase
			rz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8000));
			lz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(-int'($urandom_range(8000)));
			xt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
			yt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
			set_config(hold, window, rz, lz, xt, yt);
			if ($urandom_range(2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
			send_gesture_items(180);
		end
	endtask

	task automatic note_mismatch(input string what, input logic [1:0] want,
			input logic [1:0] got);
		bad_verdicts++;
		$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
	endtask

	// result side: check each beat, drive ready with idling and hold-off
	initial begin : result_sink
		int                hold_left;
		int                hold_seen;
		hcts_pkg::result_t want;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					note_mismatch("unexpected result, swipe", hcts_pkg::SWIPE_NONE,
						result_ch.swipe);
				end else begin
					want = pending_verdicts.pop_front();
					if (result_ch.swipe !== want.swipe)
						note_mismatch("swipe", want.swipe, result_ch.swipe);
					if (result_ch.sliding_on !== want.sliding_on)
						note_mismatch("sliding_on", 2'(want.sliding_on), 2'(result_ch.sliding_on));
					if (result_ch.sliding_changed !== want.sliding_changed)
						note_mismatch("sliding_changed", 2'(want.sliding_changed),
							2'(result_ch.sliding_changed));
				end
			end
			if (hold_seen != hold_off_req) begin
				hold_seen = hold_off_req;
				hold_left = HoldOffCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// give up after a long run of cycles with no beat on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		frame_ch.valid <= 1'b0;
		frame_ch.left_x <= '0;
		frame_ch.left_y <= '0;
		frame_ch.right_x <= '0;
		frame_ch.right_y <= '0;
		frame_ch.now_ms <= '0;
		wr_en <= 1'b0;
		wr_index <= hcts_pkg::CFG_HOLD_TIME;
		wr_data <= '0;
		live_cfg = '{hcts_pkg::HoldTimeRst, hcts_pkg::SwipeWindowRst,
			hcts_pkg::RightZoneRst, hcts_pkg::LeftZoneRst,
			hcts_pkg::XTolRst, hcts_pkg::YTolRst};
		slide_on = 1'b0;
		at_right = 1'b0;
		at_left = 1'b0;
		left_seen_ms = '0;
		right_seen_ms = '0;
		clasp_ms = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clasp_and_swipe();
		test_timestamp_wrap();
		test_register_extremes();
		test_backpressure();
		test_random_gestures();

		wait_idle();
		if (bad_verdicts == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
